// ===== rtl/auto_range_histogram_macros.svh =====
// Assertion macros for the auto-ranging histogram.
`ifndef AUTO_RANGE_HISTOGRAM_MACROS_SVH
`define AUTO_RANGE_HISTOGRAM_MACROS_SVH
`ifndef SYNTH
`define AH_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define AH_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define AH_ASSERT_IMP(lbl, ante, cons)
`define AH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/arh_pkg.sv =====
// Shared types, constants and helpers of the auto-ranging histogram.
package arh_pkg;

	localparam int unsigned DEF_MAX_BINS    = 64;
	localparam int unsigned DEF_MAX_SAMPLES = 4096;

	localparam logic [6:0]  RST_BIN_COUNT = 7'd10;
	localparam logic [15:0] RST_BAR_FRAC  = 16'd52429;
	localparam logic [32:0] HALF_UNIT     = 33'h0_0000_8000;

	typedef enum logic [1:0] {
		REG_BIN_COUNT  = 2'd0,
		REG_DENSITY    = 2'd1,
		REG_CUMULATIVE = 2'd2,
		REG_BAR_FRAC   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIV_BAR = 2'd0,
		DIV_IDX = 2'd1,
		DIV_CTR = 2'd2,
		DIV_DEN = 2'd3
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     clear;
		logic     range_latch;
		logic     bar_mul;
		logic     div_start;
		div_sel_t div_sel;
		logic     bar_latch;
		logic     sample_rd;
		logic     off_latch;
		logic     idx_mul;
		logic     idx_latch;
		logic     cnt_inc;
		logic     cnt_rd;
		logic     sum_latch;
		logic     ctr_latch;
		logic     den_mul;
		logic     den_latch;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic bins_zero;
		logic sample_end;
		logic out_last;
		logic out_fire;
		logic density;
	} dp_stat_t;

	function automatic logic [31:0] sat_u32(input logic [63:0] x);
		return (|x[63:32]) ? 32'hFFFF_FFFF : x[31:0];
	endfunction

	function automatic logic [31:0] sat_s32(input logic signed [33:0] x);
		logic [31:0] r;
		if (x > 34'sh0_7FFF_FFFF)
			r = 32'h7FFF_FFFF;
		else if (x < -34'sh0_8000_0000)
			r = 32'h8000_0000;
		else
			r = x[31:0];
		return r;
	endfunction

endpackage

// ===== rtl/arh_div.sv =====
// Restoring divider, one quotient bit per cycle, variable step count.
module arh_div import arh_pkg::*; #(
	parameter int unsigned NW  = 52,
	parameter int unsigned DW  = 45,
	parameter int unsigned QW  = 39,
	parameter int unsigned STW = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [NW-1:0]  num,
	input  logic [DW-1:0]  den,
	input  logic [STW-1:0] steps,
	output logic           done,
	output logic [QW-1:0]  quo
);

	localparam int unsigned SW = DW + QW;

	logic [NW-1:0]  rem_q;
	logic [SW-1:0]  dsh_q;
	logic [QW-1:0]  quo_q;
	logic [STW-1:0] cnt_q;
	logic           done_q;
	logic [SW-1:0]  rem_ext;
	logic           ge;

	assign rem_ext = SW'(rem_q);
	assign ge      = rem_ext >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= steps;
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == STW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= SW'(den) << (steps - 1'b1);
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			if (ge)
				rem_q <= NW'(rem_ext - dsh_q);
			quo_q <= {quo_q[QW-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/arh_dp.sv =====
// Datapath: sample store, range tracking, bin counters, arithmetic, output register.
module arh_dp import arh_pkg::*; #(
	parameter int unsigned MAX_BINS    = DEF_MAX_BINS,
	parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic [6:0]  bin_count,
	input  logic        density_mode,
	input  logic        cumulative_mode,
	input  logic [15:0] bar_frac,
	input  logic [31:0] sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] bin_center,
	output logic [31:0] bin_value,
	output logic [31:0] bar_extent,
	output logic        bin_last
);

	localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int unsigned BCW = $clog2(MAX_BINS + 1);
	localparam int unsigned IW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int unsigned NW  = (CW + BCW + 32 > 48) ? (CW + BCW + 32) : 48;
	localparam int unsigned DW  = CW + 32;
	localparam int unsigned QW  = BCW + 32;
	localparam int unsigned STW = $clog2(QW + 1);

	// set state
	logic [CW-1:0]        total_q;
	logic signed [31:0]   min_q, max_q;
	logic [MAX_BINS-1:0]  cnt_vld_q;
	logic [31:0]          smem [MAX_SAMPLES];
	logic [CW-1:0]        cmem [MAX_BINS];

	// working registers
	logic signed [32:0]   lo_q;
	logic [31:0]          range_q;
	logic [BCW-1:0]       bins_q;
	logic [CW-1:0]        n_q;
	logic [CW-1:0]        j_q;
	logic [BCW-1:0]       i_q;
	logic [47:0]          bar_prod_q;
	logic [31:0]          bar_q;
	logic [31:0]          srd_q;
	logic [31:0]          off_q;
	logic [BCW+31:0]      iprod_q;
	logic [IW-1:0]        idx_q;
	logic [CW-1:0]        crd_q;
	logic                 cvld_q;
	logic [CW-1:0]        prefix_q;
	logic [CW-1:0]        c_q;
	logic [BCW+32:0]      cnum_q;
	logic [CW+BCW-1:0]    cb_q;
	logic [CW+31:0]       nr_q;
	logic [31:0]          center_q;
	logic [31:0]          value_q;
	logic                 out_valid_q;
	logic [31:0]          o_center_q, o_value_q, o_bar_q;
	logic                 o_last_q;

	logic                 full;
	logic                 rng_eq;
	logic signed [32:0]   lo_c, hi_c, rng_c;
	logic signed [32:0]   off_c;
	logic [CW-1:0]        cnt_c, prefix_c;
	logic [BCW-1:0]       idx_w;
	logic [IW-1:0]        idx_c, crd_addr;
	logic signed [33:0]   csum_c;
	logic [BCW-1:0]       bins_c;

	logic [NW-1:0]        div_num;
	logic [DW-1:0]        div_den;
	logic [STW-1:0]       div_steps;
	logic                 div_done;
	logic [QW-1:0]        div_quo;

	assign full   = (total_q == CW'(MAX_SAMPLES));
	assign bins_c = (bin_count > 7'(MAX_BINS)) ? BCW'(MAX_BINS) : BCW'(bin_count);

	// widen a degenerate range by half a unit each side
	assign rng_eq = (min_q == max_q);
	assign lo_c   = rng_eq ? ($signed({min_q[31], min_q}) - $signed(HALF_UNIT))
	                       : $signed({min_q[31], min_q});
	assign hi_c   = rng_eq ? ($signed({max_q[31], max_q}) + $signed(HALF_UNIT))
	                       : $signed({max_q[31], max_q});
	assign rng_c  = hi_c - lo_c;

	assign off_c  = $signed({srd_q[31], srd_q}) - lo_q;

	// clamp the bin index to the top bin
	assign idx_w  = (div_quo >= QW'(bins_q)) ? (bins_q - 1'b1) : div_quo[BCW-1:0];
	assign idx_c  = idx_w[IW-1:0];

	assign cnt_c    = cvld_q ? crd_q : '0;
	assign prefix_c = prefix_q + cnt_c;
	assign csum_c   = $signed({lo_q[32], lo_q}) + $signed({2'b00, div_quo[31:0]});
	assign crd_addr = cmd.idx_latch ? idx_c : i_q[IW-1:0];

	always_comb begin
		div_num   = '0;
		div_den   = '0;
		div_steps = STW'(32);
		case (cmd.div_sel)
			DIV_BAR: begin
				div_num   = NW'(bar_prod_q);
				div_den   = DW'({bins_q, 16'h0000});
				div_steps = STW'(32);
			end
			DIV_IDX: begin
				div_num   = NW'(iprod_q);
				div_den   = DW'(range_q);
				div_steps = STW'(BCW);
			end
			DIV_CTR: begin
				div_num   = NW'(cnum_q);
				div_den   = DW'({bins_q, 1'b0});
				div_steps = STW'(32);
			end
			default: begin
				div_num   = NW'({cb_q, 32'h0000_0000});
				div_den   = DW'(nr_q);
				div_steps = STW'(QW);
			end
		endcase
	end

	arh_div #(
		.NW  (NW),
		.DW  (DW),
		.QW  (QW),
		.STW (STW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.steps  (div_steps),
		.done   (div_done),
		.quo    (div_quo)
	);

	// control state of the data set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			min_q       <= 32'sh7FFF_FFFF;
			max_q       <= 32'sh8000_0000;
			cnt_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				total_q   <= '0;
				min_q     <= 32'sh7FFF_FFFF;
				max_q     <= 32'sh8000_0000;
				cnt_vld_q <= '0;
			end else if (cmd.load && !full) begin
				total_q <= total_q + 1'b1;
				if ($signed(sample) < min_q)
					min_q <= $signed(sample);
				if ($signed(sample) > max_q)
					max_q <= $signed(sample);
			end
			if (cmd.cnt_inc)
				cnt_vld_q[idx_q] <= 1'b1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// sample store
	always_ff @(posedge clk) begin
		if (cmd.load && !full)
			smem[total_q[AW-1:0]] <= sample;
		if (cmd.sample_rd)
			srd_q <= smem[j_q[AW-1:0]];
	end

	// bin counter store
	always_ff @(posedge clk) begin
		if (cmd.cnt_inc)
			cmem[idx_q] <= cnt_c + 1'b1;
		if (cmd.idx_latch || cmd.cnt_rd) begin
			crd_q  <= cmem[crd_addr];
			cvld_q <= cnt_vld_q[crd_addr];
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.range_latch) begin
			lo_q     <= lo_c;
			range_q  <= rng_c[31:0];
			bins_q   <= bins_c;
			n_q      <= total_q;
			j_q      <= '0;
			i_q      <= '0;
			prefix_q <= '0;
		end
		if (cmd.bar_mul)
			bar_prod_q <= range_q * bar_frac;
		if (cmd.bar_latch)
			bar_q <= sat_u32(64'(div_quo));
		if (cmd.off_latch)
			off_q <= off_c[31:0];
		if (cmd.idx_mul)
			iprod_q <= off_q * bins_q;
		if (cmd.idx_latch)
			idx_q <= idx_c;
		if (cmd.cnt_inc)
			j_q <= j_q + 1'b1;
		if (cmd.sum_latch) begin
			prefix_q <= prefix_c;
			c_q      <= cumulative_mode ? prefix_c : cnt_c;
			cnum_q   <= {i_q, 1'b1} * range_q;
		end
		if (cmd.ctr_latch) begin
			center_q <= sat_s32(csum_c);
			value_q  <= sat_u32(64'({c_q, 16'h0000}));
		end
		if (cmd.den_mul) begin
			cb_q <= c_q * bins_q;
			nr_q <= n_q * range_q;
		end
		if (cmd.den_latch)
			value_q <= sat_u32(64'(div_quo));
		if (cmd.out_load) begin
			o_center_q <= center_q;
			o_value_q  <= value_q;
			o_bar_q    <= bar_q;
			o_last_q   <= (i_q == bins_q - 1'b1);
			i_q        <= i_q + 1'b1;
		end
	end

	assign stat.div_done   = div_done;
	assign stat.bins_zero  = (bins_c == '0);
	assign stat.sample_end = (j_q == n_q - 1'b1);
	assign stat.out_last   = o_last_q;
	assign stat.out_fire   = out_valid_q && out_ready;
	assign stat.density    = density_mode;

	assign out_valid  = out_valid_q;
	assign bin_center = o_center_q;
	assign bin_value  = o_value_q;
	assign bar_extent = o_bar_q;
	assign bin_last   = o_last_q;

endmodule

// ===== rtl/arh_ctrl.sv =====
// Controller: sequences loading, binning and per-bin result generation.
module arh_ctrl import arh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_last,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [19:0] {
		S_LOAD  = 20'h00001,
		S_RANGE = 20'h00002,
		S_BARM  = 20'h00004,
		S_BARS  = 20'h00008,
		S_BARW  = 20'h00010,
		S_RD    = 20'h00020,
		S_OFF   = 20'h00040,
		S_IMUL  = 20'h00080,
		S_IDIV  = 20'h00100,
		S_IWAIT = 20'h00200,
		S_INC   = 20'h00400,
		S_CRD   = 20'h00800,
		S_CSUM  = 20'h01000,
		S_CDIV  = 20'h02000,
		S_CWAIT = 20'h04000,
		S_DMUL  = 20'h08000,
		S_DDIV  = 20'h10000,
		S_DWAIT = 20'h20000,
		S_OUT   = 20'h40000,
		S_HOLD  = 20'h80000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_LOAD;
		else
			state_q <= state_d;
	end

	assign in_ready = (state_q == S_LOAD);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				cmd.load = in_valid;
				if (in_valid && in_last)
					state_d = S_RANGE;
			end
			S_RANGE: begin
				if (stat.bins_zero) begin
					cmd.clear = 1'b1;
					state_d   = S_LOAD;
				end else begin
					cmd.range_latch = 1'b1;
					state_d         = S_BARM;
				end
			end
			S_BARM: begin
				cmd.bar_mul = 1'b1;
				state_d     = S_BARS;
			end
			S_BARS: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_BAR;
				state_d       = S_BARW;
			end
			S_BARW: begin
				cmd.div_sel = DIV_BAR;
				if (stat.div_done) begin
					cmd.bar_latch = 1'b1;
					state_d       = S_RD;
				end
			end
			S_RD: begin
				cmd.sample_rd = 1'b1;
				state_d       = S_OFF;
			end
			S_OFF: begin
				cmd.off_latch = 1'b1;
				state_d       = S_IMUL;
			end
			S_IMUL: begin
				cmd.idx_mul = 1'b1;
				state_d     = S_IDIV;
			end
			S_IDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_IDX;
				state_d       = S_IWAIT;
			end
			S_IWAIT: begin
				cmd.div_sel = DIV_IDX;
				if (stat.div_done) begin
					cmd.idx_latch = 1'b1;
					state_d       = S_INC;
				end
			end
			S_INC: begin
				cmd.cnt_inc = 1'b1;
				state_d     = stat.sample_end ? S_CRD : S_RD;
			end
			S_CRD: begin
				cmd.cnt_rd = 1'b1;
				state_d    = S_CSUM;
			end
			S_CSUM: begin
				cmd.sum_latch = 1'b1;
				state_d       = S_CDIV;
			end
			S_CDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_CTR;
				state_d       = S_CWAIT;
			end
			S_CWAIT: begin
				cmd.div_sel = DIV_CTR;
				if (stat.div_done) begin
					cmd.ctr_latch = 1'b1;
					state_d       = stat.density ? S_DMUL : S_OUT;
				end
			end
			S_DMUL: begin
				cmd.den_mul = 1'b1;
				state_d     = S_DDIV;
			end
			S_DDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_DEN;
				state_d       = S_DWAIT;
			end
			S_DWAIT: begin
				cmd.div_sel = DIV_DEN;
				if (stat.div_done) begin
					cmd.den_latch = 1'b1;
					state_d       = S_OUT;
				end
			end
			S_OUT: begin
				cmd.out_load = 1'b1;
				state_d      = S_HOLD;
			end
			S_HOLD: begin
				if (stat.out_fire) begin
					if (stat.out_last) begin
						cmd.clear = 1'b1;
						state_d   = S_LOAD;
					end else begin
						state_d = S_CRD;
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

endmodule

// ===== rtl/auto_range_histogram.sv =====
// Top level of the auto-ranging histogram: register port, controller and datapath.
//
// Input channel (in_valid/in_ready): one Q16.16 sample per transfer, sample_last
// closing the data set. Samples load at one per cycle while the block is loading.
// Up to MAX_SAMPLES are stored; later samples of the same set are dropped.
// After the last sample in_ready falls and the block works the set on its own:
// range and bar width first (shared restoring divider, one quotient bit per
// cycle), then the bin of each stored sample (store read, offset, multiply,
// divide, counter update). Each bin then gets its centre, plus its density
// in density mode, before its result is offered on the output channel
// (out_valid/out_ready). The output register holds a result while the receiver
// stalls; nothing moves on until that transfer completes. After the transfer
// marked bin_last the set is cleared and in_ready rises the next cycle.
// Reset (arst_n low) clears the set and restores the register defaults; the
// sample store itself is not cleared. Registers sit on an APB port at byte
// address 4*index. The user must see that they are written only while the block
// is idle; the block itself does not enforce this.
`include "auto_range_histogram_macros.svh"
module auto_range_histogram import arh_pkg::*; #(
	parameter int unsigned MAX_BINS    = DEF_MAX_BINS,
	parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES
) (
	input  logic        clk,
	input  logic        arst_n,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// sample channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] sample,
	input  logic        sample_last,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] bin_center,
	output logic [31:0] bin_value,
	output logic [31:0] bar_extent,
	output logic        bin_last
);

	logic [6:0]  bin_count_q;
	logic        density_q;
	logic        cumulative_q;
	logic [15:0] bar_frac_q;
	reg_idx_t    reg_sel;
	logic        wr_en;
	dp_cmd_t     cmd;
	dp_stat_t    stat;

	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q  <= RST_BIN_COUNT;
			density_q    <= 1'b0;
			cumulative_q <= 1'b0;
			bar_frac_q   <= RST_BAR_FRAC;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_BIN_COUNT:  bin_count_q  <= pwdata[6:0];
				REG_DENSITY:    density_q    <= pwdata[0];
				REG_CUMULATIVE: cumulative_q <= pwdata[0];
				REG_BAR_FRAC:   bar_frac_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_BIN_COUNT:  prdata = {25'h0, bin_count_q};
			REG_DENSITY:    prdata = {31'h0, density_q};
			REG_CUMULATIVE: prdata = {31'h0, cumulative_q};
			REG_BAR_FRAC:   prdata = {16'h0, bar_frac_q};
			default:        prdata = '0;
		endcase
	end

	arh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (sample_last),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	arh_dp #(
		.MAX_BINS    (MAX_BINS),
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.bin_count       (bin_count_q),
		.density_mode    (density_q),
		.cumulative_mode (cumulative_q),
		.bar_frac        (bar_frac_q),
		.sample          (sample),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.bin_center      (bin_center),
		.bin_value       (bin_value),
		.bar_extent      (bar_extent),
		.bin_last        (bin_last)
	);

	// loading and result delivery never overlap
	`AH_ASSERT_IMP(a_no_overlap, in_ready, !out_valid)
	// the last sample hands control to the binning pass
	`AH_ASSERT_NXT(a_set_closed, in_valid && in_ready && sample_last, !in_ready)
	// the final bin transfer returns the block to loading
	`AH_ASSERT_NXT(a_set_done, out_valid && out_ready && bin_last, in_ready)

endmodule

// ===== dv/auto_range_histogram_checker.sv =====
// Result checker for the auto-ranging histogram: watches the ports, predicts each bin and compares.
`timescale 1ns / 100ps
module auto_range_histogram_checker import arh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] sample,
	input  logic        sample_last,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] bin_center,
	input  logic [31:0] bin_value,
	input  logic [31:0] bar_extent,
	input  logic        bin_last,
	output int          mismatches,
	output int          results_due
);
	localparam int BIN_CAP   = int'(DEF_MAX_BINS);
	localparam int STORE_CAP = int'(DEF_MAX_SAMPLES);

	typedef struct {
		logic [31:0] center;
		logic [31:0] value;
		logic [31:0] bar;
		logic        last;
	} bin_result_t;

	bin_result_t bins_due[$];
	int          stored[$];
	int          set_min = 32'h7FFF_FFFF;
	int          set_max = 32'h8000_0000;
	logic [6:0]  cfg_bins = RST_BIN_COUNT;
	logic        cfg_density = 1'b0;
	logic        cfg_cumulative = 1'b0;
	logic [15:0] cfg_frac = RST_BAR_FRAC;

	function automatic logic [31:0] clip_u(input longint unsigned x);
		return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
	endfunction

	function automatic logic [31:0] clip_s(input longint x);
		if (x > 64'sh7FFF_FFFF)
			return 32'h7FFF_FFFF;
		if (x < -64'sh8000_0000)
			return 32'h8000_0000;
		return x[31:0];
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Bins the closed data set and queues one result per bin.
	task automatic build_histogram();
		longint          lo, hi;
		longint unsigned span, off, idx, bar, prefix, c, val, n_samp;
		longint unsigned counts[BIN_CAP];
		int              nb;
		bin_result_t     r;
		nb = (cfg_bins > BIN_CAP) ? BIN_CAP : int'(cfg_bins);
		n_samp = stored.size();
		if (nb != 0 && n_samp != 0) begin
			lo = set_min;
			hi = set_max;
			// flat set: open the range by half a unit either side
			if (lo == hi) begin
				lo -= 64'sh8000;
				hi += 64'sh8000;
			end
			span = hi - lo;
			foreach (counts[k]) counts[k] = 0;
			foreach (stored[k]) begin
				off = longint'(stored[k]) - lo;
				idx = off * nb / span;
				if (idx >= nb) idx = nb - 1;
				counts[idx]++;
			end
			bar = span * cfg_frac / (longint'(nb) * 65536);
			prefix = 0;
			for (int i = 0; i < nb; i++) begin
				prefix += counts[i];
				c = cfg_cumulative ? prefix : counts[i];
				if (cfg_density)
					val = ((c * nb) << 32) / (n_samp * span);
				else
					val = c << 16;
				r.center = clip_s(lo + longint'((2 * longint'(i) + 1) * span / (2 * nb)));
				r.value = clip_u(val);
				r.bar = clip_u(bar);
				r.last = (i == nb - 1);
				bins_due.insert(bins_due.size(), r);
			end
		end
		stored.delete();
		set_min = 32'h7FFF_FFFF;
		set_max = 32'h8000_0000;
	endtask

	always @(posedge clk) begin
		bin_result_t w;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_BIN_COUNT:  cfg_bins = pwdata[6:0];
					REG_DENSITY:    cfg_density = pwdata[0];
					REG_CUMULATIVE: cfg_cumulative = pwdata[0];
					REG_BAR_FRAC:   cfg_frac = pwdata[15:0];
				endcase
			end
			if (in_valid && in_ready) begin
				// a full store drops the sample, last mark still closes the set
				if (stored.size() < STORE_CAP) begin
					stored.insert(stored.size(), int'(sample));
					if ($signed(sample) < set_min) set_min = sample;
					if ($signed(sample) > set_max) set_max = sample;
				end
				if (sample_last) build_histogram();
			end
			if (out_valid && out_ready) begin
				if (bins_due.size() == 0) begin
					report("unexpected transfer", bin_center, 32'h0);
				end else begin
					w = bins_due.pop_front();
					if (bin_center !== w.center) report("bin_center", bin_center, w.center);
					if (bin_value !== w.value) report("bin_value", bin_value, w.value);
					if (bar_extent !== w.bar) report("bar_extent", bar_extent, w.bar);
					if (bin_last !== w.last) report("bin_last", bin_last, w.last);
				end
			end
			results_due = bins_due.size();
		end
	end
endmodule

// ===== dv/auto_range_histogram_test.sv =====
// Testbench top for the auto-ranging histogram: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module auto_range_histogram_test;
	import arh_pkg::*;

	// worst case: each set closes with 64 bins, each bin costing its arithmetic plus
	// receiver stalls; the limit is several times that total
	localparam int CYCLE_LIMIT = 5_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0, in_ready;
	logic [31:0] sample = '0;
	logic        sample_last = 1'b0;
	logic        out_valid, out_ready = 1'b0;
	logic [31:0] bin_center, bin_value, bar_extent;
	logic        bin_last;
	int          mismatches, results_due;
	int          cycles = 0;
	bit          gaps_on = 1'b1;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	auto_range_histogram dut (.*);

	auto_range_histogram_checker chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver back-pressure: roughly 29 stalls per hundred unless gaps are off
	always @(posedge clk)
		out_ready <= !gaps_on || ($urandom_range(99) >= 29);

	// register write: setup cycle then access cycle
	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// one sample transfer; valid only drops when a sender gap is taken
	task automatic push_sample(input logic [31:0] s, input logic l);
		while (gaps_on && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		sample_last <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// let the block drain before touching registers; empty-output sets need the pause
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_config(input logic [6:0] nb, input logic dens, input logic cum,
			input logic [15:0] frac);
		reg_write(REG_BIN_COUNT, {25'd0, nb});
		reg_write(REG_DENSITY, {31'd0, dens});
		reg_write(REG_CUMULATIVE, {31'd0, cum});
		reg_write(REG_BAR_FRAC, {16'd0, frac});
	endtask

	// wide spread, a narrow cluster, or a repeated value
	function automatic logic [31:0] pick_sample(input int style, input logic [31:0] base);
		case (style)
			0:       return $urandom;
			1:       return base + $urandom_range(32'h40000);
			default: return base;
		endcase
	endfunction

	task automatic random_set(input int len);
		int          style;
		logic [31:0] base;
		style = $urandom_range(4) < 2 ? 0 : ($urandom_range(5) == 0 ? 2 : 1);
		base = $urandom;
		for (int k = 0; k < len; k++)
			push_sample(pick_sample(style, base), k == len - 1);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset defaults, single sample: flat range gets widened
		push_sample(32'h0000_0000, 1'b1);
		// full-scale extremes
		push_sample(32'h8000_0000, 1'b0);
		push_sample(32'h7FFF_FFFF, 1'b0);
		push_sample(32'hFFFF_FFFF, 1'b0);
		push_sample(32'h0000_0000, 1'b1);
		// flat set at the top and the bottom: centres saturate
		push_sample(32'h7FFF_FFFF, 1'b1);
		push_sample(32'h8000_0000, 1'b0);
		push_sample(32'h8000_0000, 1'b1);
		settle();

		set_config(7'd1, 1'b1, 1'b1, 16'hFFFF);
		push_sample(32'h0001_0000, 1'b0);
		push_sample(32'h0003_0000, 1'b1);
		settle();
		set_config(7'd64, 1'b1, 1'b0, 16'h0000);
		push_sample(32'h8000_0000, 1'b0);
		push_sample(32'h5555_5555, 1'b0);
		push_sample(32'h7FFF_FFFF, 1'b1);
		settle();
		// oversize bin count clamps to the maximum
		set_config(7'd127, 1'b0, 1'b1, 16'h8000);
		push_sample(32'hAAAA_AAAA, 1'b0);
		push_sample(32'h1234_5678, 1'b1);
		settle();
		// zero bins: set is cleared, nothing comes out
		set_config(7'd0, 1'b1, 1'b1, 16'h1234);
		push_sample(32'h0000_1000, 1'b0);
		push_sample(32'h0000_2000, 1'b1);
		settle();

		// random phases; one without any gaps
		for (int ph = 0; ph < 8; ph++) begin
			set_config(ph == 0 ? 7'd1 : (ph == 1 ? 7'd64 : 7'($urandom_range(127))),
				1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom));
			gaps_on = (ph != 3);
			for (int s = 0; s < 3; s++)
				random_set($urandom_range(10, 1));
			settle();
		end
		gaps_on = 1'b1;

		if (mismatches == 0 && results_due == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
